// ===== sv/pit_pkg.sv =====
`default_nettype none
package pit_pkg;
  localparam int BankColors = 16;
  localparam int BankCount = 16;
  localparam int MaxDimension = 256;
  localparam int ColorW = 15;

  localparam logic [1:0] RegWidth = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegOrder = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_OUT, ST_MSTART, ST_MRD, ST_MCMP, ST_MNEXT, ST_MCOPY, ST_NEWB,
    ST_NEWCOPY, ST_FINISH
  } state_t;
endpackage
`default_nettype wire

// ===== sv/palette_indexer_tile_order.sv =====
`default_nettype none
// Palette indexer. Pixels arrive bottom row first; each is reduced to a 15-bit color, looked
// up in the image bank and returned with its bank index and its destination address, with
// tlast marking the image's last pixel. Each pixel item is accepted, then one 15-bit
// comparator walks the image bank one entry per cycle, the index is registered, and the
// output register is loaded, where the result waits while an earlier result is still held.
// On the last pixel of an image a second comparator walks the stored banks once per image
// color through the bank memory's single read port, and a new bank is filled by a copy,
// before the next item is taken.
module palette_indexer_tile_order #(
  parameter int BANK_COLORS = pit_pkg::BankColors,
  parameter int BANK_COUNT = pit_pkg::BankCount,
  parameter int MAX_DIMENSION = pit_pkg::MaxDimension
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [23:0] s_tdata,   // red, green, blue
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [31:0] m_tdata,        // color_index, dest_address, bank_number,
                                      // color_overflow, palette_full, pad
  output logic m_tlast,               // image_done
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data
);
  localparam int CW = pit_pkg::ColorW;
  localparam int IW = $clog2(BANK_COLORS);
  localparam int NW = $clog2(BANK_COLORS + 1);
  localparam int BW = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
  localparam int KW = $clog2(BANK_COUNT + 1);
  localparam int AW = BW + IW;
  localparam int DW = $clog2(MAX_DIMENSION + 1);
  localparam int LIM = MAX_DIMENSION - (MAX_DIMENSION % 8);

  pit_pkg::state_t state, state_next;

  logic [8:0] reg_w, reg_h;
  logic reg_order;
  logic [CW-1:0] img [BANK_COLORS];
  logic [NW-1:0] img_cnt;
  logic [DW-1:0] col, row;
  logic ovf_seen;
  logic [NW-1:0] bsize [BANK_COUNT];
  logic [KW-1:0] bcount;

  logic [CW-1:0] color;
  logic [NW-1:0] i;
  logic [NW-1:0] j;
  logic [KW-1:0] bsel;
  logic found;
  logic [NW-1:0] wsize;
  logic [IW-1:0] idx;
  logic done_r;

  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [CW-1:0] mem_wdata, mem_rdata;

  logic [DW-1:0] w_eff, h_eff, x, y, ry;
  logic [31:0] addr_full;

  function automatic logic [DW-1:0] eff(input logic [8:0] v);
    logic [31:0] t;
    t = {23'd0, v[8:3], 3'd0};
    if (t < 32'd8) t = 32'd8;
    if (t > 32'(LIM)) t = 32'(LIM);
    return t[DW-1:0];
  endfunction

  always_comb begin
    w_eff = eff(reg_w);
    h_eff = eff(reg_h);
    x = (col < w_eff - 1'b1) ? col : w_eff - 1'b1;
    y = (row < h_eff - 1'b1) ? row : h_eff - 1'b1;
    ry = h_eff - 1'b1 - y;
    if (reg_order)
      addr_full = (32'(ry >> 3) * 32'(w_eff >> 3) << 6) + (32'(x >> 3) << 6)
                + (32'(ry[2:0]) << 3) + 32'(x[2:0]);
    else
      addr_full = 32'(ry) * 32'(w_eff) + 32'(x);
  end

  pit_bank_store #(.AW(AW)) u_store (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // The merge works on bank entries in place: a new color goes at slot wsize and stays
  // only if the whole merge succeeds (the size is committed at the end).
  always_comb begin
    state_next = state;
    case (state)
      pit_pkg::ST_IDLE: if (s_tvalid) state_next = pit_pkg::ST_SCAN;
      pit_pkg::ST_SCAN: if (found || i >= img_cnt || i >= NW'(BANK_COLORS))
        state_next = pit_pkg::ST_OUT;
      pit_pkg::ST_OUT: state_next = done_r ? pit_pkg::ST_MSTART : pit_pkg::ST_FINISH;
      pit_pkg::ST_MSTART: state_next = (bsel < bcount) ? pit_pkg::ST_MRD
                                                       : pit_pkg::ST_NEWB;
      pit_pkg::ST_MRD: state_next = (j < wsize) ? pit_pkg::ST_MCMP : pit_pkg::ST_MNEXT;
      pit_pkg::ST_MCMP: state_next = (mem_rdata == img[i[IW-1:0]]) ? pit_pkg::ST_MCOPY
                                                                  : pit_pkg::ST_MRD;
      pit_pkg::ST_MNEXT: state_next = (wsize >= NW'(BANK_COLORS - 1)) ? pit_pkg::ST_MSTART
                                                                    : pit_pkg::ST_MCOPY;
      pit_pkg::ST_MCOPY: state_next = (i + 1'b1 >= img_cnt) ? pit_pkg::ST_FINISH
                                                           : pit_pkg::ST_MRD;
      pit_pkg::ST_NEWB: state_next = (bcount >= KW'(BANK_COUNT)) ? pit_pkg::ST_FINISH
                                                                 : pit_pkg::ST_NEWCOPY;
      pit_pkg::ST_NEWCOPY: state_next = (i == NW'(BANK_COLORS - 1)) ? pit_pkg::ST_FINISH
                                                                   : pit_pkg::ST_NEWCOPY;
      pit_pkg::ST_FINISH: if (!m_tvalid || m_tready) state_next = pit_pkg::ST_IDLE;
      default: state_next = pit_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == pit_pkg::ST_IDLE);
    mem_raddr = {bsel[BW-1:0], j[IW-1:0]};
    mem_we = 1'b0;
    mem_waddr = {bsel[BW-1:0], wsize[IW-1:0]};
    mem_wdata = img[i[IW-1:0]];
    if (state == pit_pkg::ST_MNEXT && wsize < NW'(BANK_COLORS - 1)) mem_we = 1'b1;
    if (state == pit_pkg::ST_NEWCOPY) begin
      mem_we = 1'b1;
      mem_waddr = {bcount[BW-1:0], i[IW-1:0]};
    end
  end

  logic [15:0] o_addr;
  logic [3:0] o_idx, o_bank;
  logic o_done, o_ovf, o_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pit_pkg::ST_IDLE;
      reg_w <= 9'd8; reg_h <= 9'd8; reg_order <= 1'b1;
      img_cnt <= NW'(1); col <= '0; row <= '0; ovf_seen <= 1'b0;
      img[0] <= '0;
      for (int k = 0; k < BANK_COUNT; k++) bsize[k] <= '0;
      bcount <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == pit_pkg::RegWidth) reg_w <= cfg_data;
        else if (cfg_index == pit_pkg::RegHeight) reg_h <= cfg_data;
        else if (cfg_index == pit_pkg::RegOrder) reg_order <= cfg_data[0];
      end
      if (state == pit_pkg::ST_FINISH && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        pit_pkg::ST_IDLE: if (s_tvalid) begin
          color <= {s_tdata[23:19], s_tdata[15:11], s_tdata[7:3]};
          i <= '0; found <= 1'b0;
        end
        pit_pkg::ST_SCAN: begin
          if (!found && i < img_cnt && i < NW'(BANK_COLORS)) begin
            if (img[i[IW-1:0]] == color) begin found <= 1'b1; idx <= i[IW-1:0]; end
            else i <= i + 1'b1;
          end
        end
        pit_pkg::ST_OUT: begin
          if (!found) begin
            if (img_cnt < NW'(BANK_COLORS)) begin
              img[img_cnt[IW-1:0]] <= color;
              o_idx <= 4'(img_cnt);
              img_cnt <= img_cnt + 1'b1;
              o_ovf <= ovf_seen;
            end else begin
              o_idx <= '0; ovf_seen <= 1'b1; o_ovf <= 1'b1;
            end
          end else begin
            o_idx <= 4'(idx); o_ovf <= ovf_seen;
          end
          o_bank <= '0; o_full <= 1'b0; o_done <= done_r;
          bsel <= '0;
        end
        pit_pkg::ST_MSTART: begin
          i <= '0; j <= '0;
          wsize <= (bsel < bcount) ? bsize[bsel[BW-1:0]] : '0;
        end
        pit_pkg::ST_MRD: if (j >= wsize) j <= j;
        pit_pkg::ST_MCMP: if (mem_rdata != img[i[IW-1:0]]) j <= j + 1'b1;
        pit_pkg::ST_MNEXT: if (wsize >= NW'(BANK_COLORS - 1)) bsel <= bsel + 1'b1;
          else wsize <= wsize + 1'b1;
        pit_pkg::ST_MCOPY: begin
          j <= '0;
          if (i + 1'b1 >= img_cnt) begin
            bsize[bsel[BW-1:0]] <= wsize; o_bank <= 4'(bsel);
          end else i <= i + 1'b1;
        end
        pit_pkg::ST_NEWB: begin
          i <= '0;
          if (bcount >= KW'(BANK_COUNT)) o_full <= 1'b1;
        end
        pit_pkg::ST_NEWCOPY: begin
          i <= i + 1'b1;
          if (i == NW'(BANK_COLORS - 1)) begin
            bsize[bcount[BW-1:0]] <= img_cnt; o_bank <= 4'(bcount);
            bcount <= bcount + 1'b1;
          end
        end
        pit_pkg::ST_FINISH: if (!m_tvalid || m_tready) begin
          m_tdata <= {6'd0, o_full, o_ovf, o_bank, o_addr, o_idx};
          m_tlast <= o_done;
          if (o_done) begin
            img_cnt <= NW'(1); ovf_seen <= 1'b0; img[0] <= '0;
          end
        end
        default: ;
      endcase
      // The address is taken from the position of this pixel, before the counters move on.
      if (state == pit_pkg::ST_SCAN && state_next == pit_pkg::ST_OUT) begin
        o_addr <= addr_full[15:0];
        if (col >= w_eff - 1'b1) begin
          col <= '0;
          if (row >= h_eff - 1'b1) begin done_r <= 1'b1; row <= '0; end
          else begin done_r <= 1'b0; row <= row + 1'b1; end
        end else begin
          done_r <= 1'b0; col <= col + 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) s_tready |-> state == pit_pkg::ST_IDLE)
    else $error("ready outside idle");
  assert property (@(posedge clk) disable iff (rst) img_cnt != '0)
    else $error("empty image bank");
  assert property (@(posedge clk) disable iff (rst) bcount <= KW'(BANK_COUNT))
    else $error("bank count past limit");
  assert property (@(posedge clk) disable iff (rst)
                   m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("held result changed");
endmodule
`default_nettype wire

// ===== sv/pit_bank_store.sv =====
`default_nettype none
// Stored bank colors: one write port, one registered read port.
module pit_bank_store #(
  parameter int AW = 8
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [pit_pkg::ColorW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [pit_pkg::ColorW-1:0] rdata
);
  logic [pit_pkg::ColorW-1:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

typedef struct {
  logic [3:0]  color_index;
  logic [15:0] dest_address;
  logic        image_done;
  logic [3:0]  bank_number;
  logic        color_overflow;
  logic        palette_full;
} pixel_result_t;

class palette_scoreboard;
  int unsigned width_reg = 8;
  int unsigned height_reg = 8;
  int unsigned tile_mode = 1;
  logic [14:0] image_colors[16];
  int unsigned image_count = 1;
  int unsigned column;
  int unsigned row;
  bit overflow_seen;
  logic [14:0] bank_colors[16][16];
  int unsigned bank_sizes[16];
  int unsigned bank_total;
  pixel_result_t pending[$];
  int errors;

  function new();
    clear_image();
    foreach (bank_sizes[i]) bank_sizes[i] = 0;
    bank_total = 0;
    errors = 0;
  endfunction

  function void clear_image();
    foreach (image_colors[i]) image_colors[i] = '0;
    image_count = 1;
    column = 0;
    row = 0;
    overflow_seen = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [8:0] val);
    if (idx == pit_pkg::RegWidth) width_reg = 32'(val);
    else if (idx == pit_pkg::RegHeight) height_reg = 32'(val);
    else if (idx == pit_pkg::RegOrder) tile_mode = 32'(val[0]);
  endfunction

  function int unsigned usable_dim(int unsigned v);
    v = v & ~32'd7;
    if (v < 8) v = 8;
    if (v > 256) v = 256;
    return v;
  endfunction

  function bit merge_into(int unsigned b);
    logic [14:0] work[16];
    int unsigned size;
    bit found;
    size = bank_sizes[b] > 16 ? 16 : bank_sizes[b];
    work = bank_colors[b];
    for (int i = 0; i < image_count && i < 16; i++) begin
      found = 0;
      for (int j = 0; j < size; j++)
        if (work[j] == image_colors[i]) begin
          found = 1;
          break;
        end
      if (!found) begin
        if (size >= 15) return 0;
        work[size] = image_colors[i];
        size++;
      end
    end
    bank_colors[b] = work;
    bank_sizes[b] = size;
    return 1;
  endfunction

  function bit at_image_start();
    return column == 0 && row == 0;
  endfunction

  function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned w, h, x, y, ry, addr;
    logic [14:0] c;
    pixel_result_t res;
    bit found, placed;
    w = usable_dim(width_reg);
    h = usable_dim(height_reg);
    c = {b[7:3], g[7:3], r[7:3]};
    x = column < w - 1 ? column : w - 1;
    y = row < h - 1 ? row : h - 1;
    ry = h - 1 - y;
    if (tile_mode)
      addr = (ry >> 3) * 64 * (w >> 3) + (x >> 3) * 64 + (ry & 7) * 8 + (x & 7);
    else addr = ry * w + x;
    res.color_index = 0;
    res.image_done = 0;
    res.bank_number = 0;
    res.palette_full = 0;
    found = 0;
    for (int i = 0; i < image_count && i < 16; i++)
      if (image_colors[i] == c) begin
        res.color_index = 4'(i);
        found = 1;
        break;
      end
    if (!found) begin
      if (image_count < 16) begin
        image_colors[image_count] = c;
        res.color_index = 4'(image_count);
        image_count++;
      end else begin
        overflow_seen = 1;
      end
    end
    res.color_overflow = overflow_seen;
    res.dest_address = addr[15:0];
    if (column >= w - 1) begin
      column = 0;
      if (row >= h - 1) res.image_done = 1;
      else row++;
    end else begin
      column++;
    end
    if (res.image_done) begin
      placed = 0;
      for (int i = 0; i < bank_total && i < 16; i++)
        if (merge_into(i)) begin
          res.bank_number = 4'(i);
          placed = 1;
          break;
        end
      if (!placed) begin
        if (bank_total < 16) begin
          bank_colors[bank_total] = image_colors;
          bank_sizes[bank_total] = image_count;
          res.bank_number = 4'(bank_total);
          bank_total++;
        end else begin
          res.palette_full = 1;
        end
      end
      clear_image();
    end
    pending.push_back(res);
  endfunction

  function void check_result(logic [31:0] d, logic l, time t);
    pixel_result_t e;
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: unexpected item tdata=%h tlast=%b", t, d, l);
      return;
    end
    e = pending.pop_front();
    if (d[3:0] !== e.color_index || d[19:4] !== e.dest_address || l !== e.image_done
        || d[23:20] !== e.bank_number || d[24] !== e.color_overflow
        || d[25] !== e.palette_full) begin
      errors++;
      $display("%0t: mismatch expected idx=%0d addr=%0d done=%0d bank=%0d ovf=%0d full=%0d",
               t, e.color_index, e.dest_address, e.image_done, e.bank_number,
               e.color_overflow, e.palette_full);
      $display("%0t: mismatch actual   idx=%0d addr=%0d done=%0d bank=%0d ovf=%0d full=%0d",
               t, d[3:0], d[19:4], l, d[23:20], d[24], d[25]);
    end
  endfunction
endclass

module tb_top;
  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [31:0] m_tdata;
  logic m_tlast;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  palette_scoreboard board = new();
  int send_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int sent = 0;
  logic [23:0] color_pool[256];

  palette_indexer_tile_order dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata, m_tlast, $time);

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold = 600;
        hold_request = 0;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    #(12 * 4000000);
    $display("Test completed with failures");
    $finish;
  end

  // The caller drops cfg_we after its last write.
  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic set_dims(int w, int h, int ord);
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    write_reg(pit_pkg::RegWidth, 9'(w));
    write_reg(pit_pkg::RegHeight, 9'(h));
    write_reg(pit_pkg::RegOrder, 9'(ord));
    cfg_we <= 0;
  endtask

  // tvalid stays high after an accept until the next item or an idle gap replaces it.
  task automatic send_pixel(logic [23:0] px);
    if ($urandom_range(0, 99) < send_pct) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_pixel(px[7:0], px[15:8], px[23:16]);
    sent++;
  endtask

  // Pixels of one image come from a window of the pool, so the window size decides
  // whether the image bank overflows and how often stored banks can be shared.
  task automatic send_image(int base, int span, int limit);
    int n;
    logic [23:0] px;
    n = 0;
    do begin
      if ($urandom_range(0, 9) == 0) px = 24'($urandom);
      else px = color_pool[(base + $urandom_range(0, span - 1)) % 256]
                | 24'($urandom & 24'h070707);
      send_pixel(px);
      n++;
    end while (!board.at_image_start() && n < limit);
  endtask

  task automatic set_idling(int mode);
    send_pct = (mode == 1) ? 53 : (mode == 3) ? 33 : 0;
    stall_pct = (mode == 2) ? 53 : (mode == 3) ? 33 : 0;
  endtask

  initial begin
    int mode;
    logic [23:0] corners[10];
    corners = '{24'h000000, 24'hFFFFFF, 24'h070707, 24'h000008, 24'h000800,
                24'h080000, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hF8F8F8};
    for (int i = 0; i < 256; i++)
      color_pool[i] = {i[7:0] ^ 8'h5A, i[7:0], 8'hFF - i[7:0]} & 24'hF8F8F8;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Extreme channel values with the reset configuration, then the image is finished.
    foreach (corners[i]) send_pixel(corners[i]);
    send_image(0, 4, 1000);

    set_dims(16, 8, 0);
    set_idling(1);
    send_image(10, 6, 1000);

    // Unaligned and out-of-range sizes clamp to 8; twenty colors overflow the bank.
    set_dims(0, 13, 1);
    set_idling(2);
    send_image(40, 20, 1000);

    // Large dimensions for a while, then shrunk in the middle of the image.
    set_dims(511, 256, 1);
    set_idling(3);
    send_image(70, 3, 40);
    set_dims(256, 256, 0);
    send_image(70, 3, 20);
    set_dims(9, 8, 1);
    send_image(70, 3, 1000);

    set_idling(0);
    set_dims(8, 8, 0);
    hold_request = 1;
    send_image(80, 5, 1000);

    mode = 0;
    while (sent < 1700) begin
      set_dims($urandom_range(0, 3) == 0 ? 16 : 8, $urandom_range(0, 5) == 0 ? 16 : 8,
               $urandom_range(0, 1));
      set_idling(mode);
      mode = (mode + 1) % 4;
      if ($urandom_range(0, 1)) send_image($urandom_range(0, 3) * 4, $urandom_range(1, 12), 1000);
      else send_image($urandom_range(0, 255), $urandom_range(1, 20), 1000);
    end

    s_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== sim.f =====
sv/pit_pkg.sv
sv/pit_bank_store.sv
sv/palette_indexer_tile_order.sv
tb/tb_top.sv
